// ===== hw/rtl/hees_pkg.sv =====
// Shared types and constants for the explicit 1D heat equation solver.
// No dependencies; used by every module of the block.
package hees_pkg;

  // Default row length and the depth of the queue between the front and back ends
  localparam int DEF_MAX_POINTS = 64;
  localparam int QUEUE_DEPTH    = 4;

  localparam int DATA_W  = 32;
  localparam int RATIO_W = 16;
  localparam int STEPS_W = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATIO = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOUNDARY   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOUNDARY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT      = 8'd3;

  // Reset values
  localparam logic [RATIO_W-1:0]       RST_RATIO = 16'd6554;
  localparam logic signed [DATA_W-1:0] RST_LEFT  = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_RIGHT = 32'sd0;
  localparam logic [STEPS_W-1:0]       RST_STEPS = 16'd100;

  typedef struct packed {
    logic [RATIO_W-1:0]       diffusion_ratio;
    logic signed [DATA_W-1:0] left_boundary;
    logic signed [DATA_W-1:0] right_boundary;
    logic [STEPS_W-1:0]       step_count;
  } cfg_t;

  // One classified request from the front end
  typedef struct packed {
    logic signed [DATA_W-1:0] temp;
    logic                     keep;   // point fits in the row store
    logic                     final_pt;
  } req_t;

endpackage

// ===== hw/rtl/hees_front.sv =====
// Front end: accepts input requests, tracks the row fill and classifies each point.
// Depends on hees_pkg.
module hees_front #(
  parameter int MAX_POINTS = hees_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hees_pkg::DATA_W-1:0]  start_temp,
  input  logic                                final_point,
  input  logic                                q_full,
  output logic                                q_push,
  output hees_pkg::req_t                      q_req,
  output logic [$clog2(MAX_POINTS)-1:0]       q_addr,
  output logic [$clog2(MAX_POINTS+1)-1:0]     q_npts
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);

  logic [CW-1:0] cnt, cnt_next;
  logic          keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = cnt < CW'(MAX_POINTS);

  assign q_req.temp     = start_temp;
  assign q_req.keep     = keep;
  assign q_req.final_pt = final_point;
  assign q_addr         = cnt[AW-1:0];
  assign q_npts         = keep ? cnt + CW'(1) : cnt;

  always_comb begin
    cnt_next = cnt;
    if (q_push) begin
      if (final_point) cnt_next = '0;
      else             cnt_next = q_npts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end
endmodule

// ===== hw/rtl/hees_queue.sv =====
// Small FIFO of classified requests between the front and back ends.
// Depends on hees_pkg for its default depth.
module hees_queue #(
  parameter int W     = 8,
  parameter int DEPTH = hees_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         not_empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full      = fill == CW'(DEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end
endmodule

// ===== hw/rtl/hees_back.sv =====
// Back end: row stores, stencil sweep pipeline and row emission.
// Depends on hees_pkg.
module hees_back #(
  parameter int MAX_POINTS = hees_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hees_pkg::cfg_t                      cfg,
  input  logic                                q_valid,
  input  hees_pkg::req_t                      q_req,
  input  logic [$clog2(MAX_POINTS)-1:0]       q_addr,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     q_npts,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hees_pkg::DATA_W-1:0]  temperature,
  output logic                                row_end
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int DW = hees_pkg::DATA_W;
  localparam int LW = DW + 3;                  // laplacian
  localparam int PW = LW + hees_pkg::RATIO_W + 1;  // product
  localparam int SW = DW + 5;                  // mid + delta
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);
  localparam logic signed [PW-1:0] HALF   = PW'(32768);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t st;
  logic   active;                       // 0: row_a current, 1: row_b
  logic [CW-1:0] n, iss_e, em_i;
  logic [hees_pkg::STEPS_W-1:0] steps;

  // row stores
  logic signed [DW-1:0] row_a [MAX_POINTS];
  logic signed [DW-1:0] row_b [MAX_POINTS];
  logic signed [DW-1:0] a_q, b_q, rd_data, wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic we_a, we_b, ld_we;

  // sweep pipeline
  logic                 p1_v, p2_v, p3_v;
  logic [CW-1:0]        p1_e;
  logic signed [DW-1:0] win_l, win_m, x;
  logic signed [LW-1:0] lap, p2_lap;
  logic signed [DW-1:0] p2_mid, p3_mid;
  logic [AW-1:0]        p2_idx, p3_idx;
  logic signed [PW-1:0] p3_prod, rnd;
  logic signed [SW-1:0] sum;
  logic signed [DW-1:0] sat_val;

  // emission
  logic em_issue, em_pend, em_last;

  assign q_pop = (st == ST_IDLE) && q_valid;
  assign ld_we = q_pop && q_req.keep;

  assign rd_addr = (st == ST_SWEEP) ? iss_e[AW-1:0] : em_i[AW-1:0];
  assign wr_addr = ld_we ? q_addr : p3_idx;
  assign wr_data = ld_we ? q_req.temp : sat_val;
  assign we_a    = (ld_we && !active) || (p3_v && active);
  assign we_b    = (ld_we && active) || (p3_v && !active);
  assign rd_data = active ? b_q : a_q;

  always_ff @(posedge clk) begin
    if (we_a) row_a[wr_addr] <= wr_data;
    a_q <= row_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) row_b[wr_addr] <= wr_data;
    b_q <= row_b[rd_addr];
  end

  // right neighbour: store data, or the boundary on the flush event
  assign x   = (p1_e == n) ? cfg.right_boundary : rd_data;
  assign lap = LW'(win_l) - (LW'(win_m) <<< 1) + LW'(x);

  // round half up, add, saturate
  assign rnd     = p3_prod + HALF;
  assign sum     = SW'(p3_mid) + SW'($signed(rnd[PW-1:16]));
  assign sat_val = (sum > SAT_HI) ? DW'(SAT_HI) :
                   (sum < SAT_LO) ? DW'(SAT_LO) : sum[DW-1:0];

  assign em_issue = (st == ST_EMIT) && !em_pend && (em_i != n) && (!out_valid || out_ready);

  // datapath registers
  always_ff @(posedge clk) begin
    p1_e <= iss_e;
    if (p1_v) begin
      if (p1_e == '0) win_l <= cfg.left_boundary;
      else            win_l <= win_m;
      win_m  <= x;
      p2_lap <= lap;
      p2_mid <= win_m;
      p2_idx <= AW'(p1_e - CW'(1));
    end
    p3_prod <= $signed({1'b0, cfg.diffusion_ratio}) * p2_lap;
    p3_mid  <= p2_mid;
    p3_idx  <= p2_idx;
    em_last <= em_i == n - CW'(1);
    if (em_pend) begin
      temperature <= rd_data;
      row_end     <= em_last;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      active    <= 1'b0;
      n         <= '0;
      iss_e     <= '0;
      em_i      <= '0;
      steps     <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      em_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_v    <= st == ST_SWEEP;
      p2_v    <= p1_v && (p1_e != '0);
      p3_v    <= p2_v;
      em_pend <= em_issue;
      if (em_issue) em_i <= em_i + CW'(1);
      if (em_pend)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (st)
        ST_IDLE: begin
          if (q_pop && q_req.final_pt) begin
            n     <= q_npts;
            steps <= cfg.step_count;
            iss_e <= '0;
            em_i  <= '0;
            st    <= (cfg.step_count == '0) ? ST_EMIT : ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          iss_e <= iss_e + CW'(1);
          if (iss_e == n) st <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v) begin
            active <= ~active;
            steps  <= steps - 1'b1;
            iss_e  <= '0;
            st     <= (steps == 16'd1) ? ST_EMIT : ST_SWEEP;
          end
        end
        ST_EMIT: begin
          if (em_i == n && !em_pend) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/heat_equation_explicit_solver.sv =====
// Explicit (FTCS) 1D heat equation solver: top level with configuration registers.
// Depends on hees_pkg, hees_front, hees_queue and hees_back.
//
// A row is loaded one point per input request, up to MAX_POINTS points (extra points
// are dropped); the request carrying final_point starts the run. The block then runs
// step_count sweeps of next = mid + r*(left - 2*mid + right) in Q16.16 with round
// half up and 32-bit saturation, ping-ponging between two row stores, and returns the
// row one point per request with row_end on the last. Each sweep reads each point once
// through the single read port of a row store, then flushes in the right boundary and
// drains the pipeline; emission alternates the read port and the output register and
// holds while the output stalls. Requests for the next row queue up behind a run in a
// four-deep queue, and are written once the current row has been emitted. step_count
// is latched at the start of a run; the ratio and boundaries are read live.
// Configuration writes are meant only while the block is idle; unknown register
// indexes are ignored.
module heat_equation_explicit_solver #(
  parameter int MAX_POINTS = hees_pkg::DEF_MAX_POINTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input requests
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [hees_pkg::DATA_W-1:0]     start_temp,
  input  logic                                   final_point,
  // result requests
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [hees_pkg::DATA_W-1:0]     temperature,
  output logic                                   row_end,
  // configuration
  input  logic                                   cfg_we,
  input  logic [hees_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hees_pkg::CFG_DATA_W-1:0]        cfg_data
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int QW = $bits(hees_pkg::req_t) + AW + CW;

  hees_pkg::cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diffusion_ratio <= hees_pkg::RST_RATIO;
      cfg.left_boundary   <= hees_pkg::RST_LEFT;
      cfg.right_boundary  <= hees_pkg::RST_RIGHT;
      cfg.step_count      <= hees_pkg::RST_STEPS;
    end else if (cfg_we) begin
      case (cfg_index)
        hees_pkg::REG_DIFFUSION_RATIO: cfg.diffusion_ratio <= cfg_data[15:0];
        hees_pkg::REG_LEFT_BOUNDARY:   cfg.left_boundary   <= $signed(cfg_data);
        hees_pkg::REG_RIGHT_BOUNDARY:  cfg.right_boundary  <= $signed(cfg_data);
        hees_pkg::REG_STEP_COUNT:      cfg.step_count      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end -> queue
  logic           f_push, q_full, q_valid, q_pop;
  hees_pkg::req_t f_req, b_req;
  logic [AW-1:0]  f_addr, b_addr;
  logic [CW-1:0]  f_npts, b_npts;
  logic [QW-1:0]  q_out;

  hees_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_temp  (start_temp),
    .final_point (final_point),
    .q_full      (q_full),
    .q_push      (f_push),
    .q_req       (f_req),
    .q_addr      (f_addr),
    .q_npts      (f_npts)
  );

  hees_queue #(.W(QW), .DEPTH(hees_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_req, f_addr, f_npts}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  assign {b_req, b_addr, b_npts} = q_out;

  // Back end: sweeps and emission
  hees_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_req       (b_req),
    .q_addr      (b_addr),
    .q_npts      (b_npts),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .temperature (temperature),
    .row_end     (row_end)
  );
endmodule

// ===== hw/rtl/hees_checker.sv =====
// Port-level checks for the heat equation solver, bound to the top level.
// Depends on heat_equation_explicit_solver port names only.
module hees_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        final_point,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] temperature,
  input logic        row_end
);
  // rows requested but not yet fully returned
  logic [3:0] rows_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_open <= '0;
    end else begin
      rows_open <= rows_open + 4'(in_valid && in_ready && final_point)
                             - 4'(out_valid && out_ready && row_end);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(row_end))
    else $error("result request changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready straight after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rows_open != 4'd0)
    else $error("result without an open row");
endmodule

bind heat_equation_explicit_solver hees_checker u_hees_checker (.*);
